/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the cipher unit RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled during reset
`define ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* rtl/mecu_pkg.sv */
// ----------------------------------------------------------------------------
// Cipher unit package
// Shared types and constants for the modular exponentiation cipher unit.
// ----------------------------------------------------------------------------
package mecu_pkg;

  // Modulus after reset
  localparam int unsigned MODULUS_RESET = 103;

  // Status from the serial multiplier to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } mul_status_t;

endpackage

/* rtl/mecu_modmul.sv */
// ----------------------------------------------------------------------------
// Serial modular multiplier
// Interleaved shift-add a*b mod m, one multiplier bit per cycle, MSB first.
// Operand a and the running sum stay below m.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mecu_modmul #(
  parameter int VALUE_BITS = 13
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [VALUE_BITS-1:0]   a,
  input  logic [VALUE_BITS-1:0]   b,
  input  logic [VALUE_BITS-1:0]   m,
  output logic [VALUE_BITS-1:0]   product,
  output mecu_pkg::mul_status_t   status
);

  localparam int CW = $clog2(VALUE_BITS);
  localparam logic [CW-1:0] LAST = CW'(VALUE_BITS - 1);

  logic [VALUE_BITS-1:0] acc;
  logic [VALUE_BITS-1:0] acc_next;
  logic [VALUE_BITS-1:0] bsh;
  logic [CW-1:0]         cnt;
  logic                  busy;
  logic                  done;

  logic [VALUE_BITS:0]   dbl;
  logic [VALUE_BITS-1:0] dbl_red;
  logic [VALUE_BITS:0]   sum;
  logic [VALUE_BITS:0]   m_ext;

  // Double, reduce, add the selected operand, reduce again
  always_comb begin
    m_ext   = {1'b0, m};
    dbl     = {acc, 1'b0};
    dbl_red = (dbl >= m_ext) ? VALUE_BITS'(dbl - m_ext) : dbl[VALUE_BITS-1:0];
    sum     = {1'b0, dbl_red} + (bsh[VALUE_BITS-1] ? {1'b0, a} : '0);
    acc_next = (sum >= m_ext) ? VALUE_BITS'(sum - m_ext) : sum[VALUE_BITS-1:0];
  end

  // Advance one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        acc  <= '0;
        bsh  <= b;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        acc <= acc_next;
        bsh <= {bsh[VALUE_BITS-2:0], 1'b0};
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign product     = acc;
  assign status.busy = busy;
  assign status.done = done;

  `ASSERT_NXT(a_start_busy, clk, rst, start, busy)
  `ASSERT_IMP(a_done_idle, clk, rst, done, !busy)
  `ASSERT_IMP(a_acc_reduced, clk, rst, busy && (m >= 2) && (a < m), acc < m)

endmodule

/* rtl/modular_exponentiation_cipher_unit.sv */
// ----------------------------------------------------------------------------
// Modular exponentiation cipher unit
// Returns base_value ** exponent mod modulus, fully reduced.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one request: base_value, exponent.
//   Output channel (out_valid/out_ready) returns one result_value per request.
//   Config channel (cfg_valid/cfg_ready) writes the modulus; write it only
//   while no request is in flight. A modulus below 2 gives a result of 0.
//   One request is worked at a time. The base is first reduced by one serial
//   multiply, then each of VALUE_BITS exponent bits takes a step state, a
//   square and, for a set bit, a multiply. Every multiply runs on the single
//   bit-serial modular multiplier. The result sits in an output register;
//   the next request is taken while it waits. If the receiver stalls and a
//   second result is ready, the unit holds in its final state until the
//   register frees. Reset clears control state and loads modulus 103.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module modular_exponentiation_cipher_unit #(
  parameter int VALUE_BITS = 13
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [VALUE_BITS-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VALUE_BITS-1:0] base_value,
  input  logic [VALUE_BITS-1:0] exponent,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [VALUE_BITS-1:0] result_value
);

  localparam int CW = $clog2(VALUE_BITS);
  localparam logic [CW-1:0] LAST = CW'(VALUE_BITS - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_RED, S_STEP, S_MUL, S_SQR, S_OUT
  } state_t;

  state_t                state;
  logic [VALUE_BITS-1:0] modulus;
  logic [VALUE_BITS-1:0] exp_sh;
  logic [VALUE_BITS-1:0] acc;
  logic [VALUE_BITS-1:0] sq;
  logic [CW-1:0]         bit_cnt;
  logic                  mul_go;
  logic [VALUE_BITS-1:0] mul_a;
  logic [VALUE_BITS-1:0] mul_b;
  logic [VALUE_BITS-1:0] mul_p;
  mecu_pkg::mul_status_t mul_st;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  // Shared serial multiplier
  mecu_modmul #(.VALUE_BITS(VALUE_BITS)) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_go),
    .a       (mul_a),
    .b       (mul_b),
    .m       (modulus),
    .product (mul_p),
    .status  (mul_st)
  );

  // Sequence the square-and-multiply and hold the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      modulus   <= VALUE_BITS'(mecu_pkg::MODULUS_RESET);
      out_valid <= 1'b0;
      mul_go    <= 1'b0;
      bit_cnt   <= '0;
    end else begin
      mul_go <= 1'b0;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cfg_valid && cfg_ready) modulus <= cfg_data;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            exp_sh  <= exponent;
            bit_cnt <= '0;
            if (modulus < VALUE_BITS'(2)) begin
              acc   <= '0;
              state <= S_OUT;
            end else begin
              mul_a  <= VALUE_BITS'(1);
              mul_b  <= base_value;
              mul_go <= 1'b1;
              state  <= S_RED;
            end
          end
        end
        S_RED: begin
          if (mul_st.done) begin
            sq    <= mul_p;
            acc   <= VALUE_BITS'(1);
            state <= S_STEP;
          end
        end
        S_STEP: begin
          mul_go <= 1'b1;
          mul_a  <= sq;
          if (exp_sh[0]) begin
            mul_b <= acc;
            state <= S_MUL;
          end else begin
            mul_b <= sq;
            state <= S_SQR;
          end
        end
        S_MUL: begin
          if (mul_st.done) begin
            acc    <= mul_p;
            mul_a  <= sq;
            mul_b  <= sq;
            mul_go <= 1'b1;
            state  <= S_SQR;
          end
        end
        S_SQR: begin
          if (mul_st.done) begin
            sq      <= mul_p;
            exp_sh  <= exp_sh >> 1;
            bit_cnt <= bit_cnt + 1'b1;
            state   <= (bit_cnt == LAST) ? S_OUT : S_STEP;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            result_value <= acc;
            out_valid    <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_NXT(a_accept_leaves_idle, clk, rst, in_valid && in_ready, state != S_IDLE)
  `ASSERT_IMP(a_go_when_free, clk, rst, mul_go, !mul_st.busy)
  `ASSERT_IMP(a_wait_has_work, clk, rst,
    state == S_RED || state == S_MUL || state == S_SQR, mul_go || mul_st.busy || mul_st.done)
  `ASSERT_IMP(a_result_reduced, clk, rst,
    out_valid && (modulus >= VALUE_BITS'(2)), result_value < modulus)

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Modular exponentiation cipher unit testbench
// Drives base/exponent requests under random idling and a long output stall,
// predicts base ** exponent mod modulus for each one, and checks each result
// in order against the predicted value. The modulus is rewritten between
// phases while the unit is idle.
// ----------------------------------------------------------------------------
module testbench;

  localparam int VB = 13;
  localparam int MAX_MOD = (1 << VB) - 1;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [VB-1:0] cfg_data = '0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic [VB-1:0] base_value = '0;
  logic [VB-1:0] exponent = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [VB-1:0] result_value;

  logic [VB-1:0] cur_modulus = VB'(mecu_pkg::MODULUS_RESET);
  logic [VB-1:0] expected_powers[$];
  int            mismatches = 0;
  bit            calm = 1'b0;
  bit            hold_go = 1'b0;
  int            hold_cycles = 0;

  modular_exponentiation_cipher_unit #(.VALUE_BITS(VB)) dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .base_value(base_value), .exponent(exponent),
    .out_valid(out_valid), .out_ready(out_ready), .result_value(result_value)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Square-and-multiply over every exponent bit
  function automatic logic [VB-1:0] power_mod(logic [VB-1:0] b, logic [VB-1:0] e,
                                              logic [VB-1:0] m);
    logic [31:0] acc;
    logic [31:0] sq;
    if (m < 2) return '0;
    acc = 1;
    sq = b % m;
    for (int i = 0; i < VB; i++) begin
      if (e[i]) acc = (acc * sq) % m;
      sq = (sq * sq) % m;
    end
    return acc[VB-1:0];
  endfunction

  // Send one request, idling first at random; valid drops only while idling
  task automatic send_request(logic [VB-1:0] b, logic [VB-1:0] e);
    while (!calm && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    base_value <= b;
    exponent <= e;
    expected_powers.push_back(power_mod(b, e, cur_modulus));
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop the input, wait for all results, then write the modulus
  task automatic write_modulus(logic [VB-1:0] m);
    in_valid <= 1'b0;
    while (expected_powers.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_modulus = m;
  endtask

  // Receiver: random stalls, plus a counted long hold
  always @(posedge clk) begin
    if (hold_go) begin
      hold_cycles <= 3000;
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 38);
    end
  end

  // Check each result against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_powers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d", result_value);
      end else begin
        if (result_value !== expected_powers[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result: expected %0d, got %0d", expected_powers[0], result_value);
        end
        void'(expected_powers.pop_front());
      end
    end
  end

  task automatic test_edge_values();
    send_request(0, 0);
    send_request(MAX_MOD, MAX_MOD);
    send_request(0, 5);
    send_request(1, MAX_MOD);
    send_request(102, 1);
    send_request(103, 7);
    send_request(MAX_MOD, 0);
    send_request(5, 1);
    send_request(2, 13'h1555);
    send_request(13'h0aaa, 13'h0aaa);
  endtask

  task automatic test_modulus_range();
    logic [VB-1:0] mods[6] = '{2, MAX_MOD, 8191 - 2, 0, 1, 13};
    foreach (mods[i]) begin
      write_modulus(mods[i]);
      send_request(MAX_MOD, MAX_MOD);
      send_request(0, 0);
      send_request(mods[i], 3);
      send_request(13'($urandom), 0);
    end
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++)
      send_request(13'($urandom), 13'($urandom));
  endtask

  task automatic test_backpressure();
    calm = 1'b1;
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    test_random(8);
    calm = 1'b0;
  endtask

  task automatic test_calm_stretch();
    calm = 1'b1;
    test_random(40);
    calm = 1'b0;
  endtask

  initial begin
    logic [VB-1:0] picks[4] = '{8191, 7919, 257, 103};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_edge_values();
    test_modulus_range();
    foreach (picks[i]) begin
      write_modulus(picks[i]);
      test_random(100);
    end
    write_modulus(13'($urandom_range(MAX_MOD, 2)));
    test_backpressure();
    test_calm_stretch();
    test_random(40);
    in_valid <= 1'b0;
    while (expected_powers.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // Hold-off watchdog
  initial begin
    #(12 * 2000000);
    $display("Mismatches found");
    $finish;
  end
endmodule
